// ----- rtl/fpp_pkg.sv -----
// Shared types and the control program for the Fibonacci residue block.
// Holds the step counter type, the datapath operation and jump condition codes,
// and the microcode table. No dependencies.
`default_nettype none

package fpp_pkg;

    localparam int STEP_W    = 3;
    localparam int RESIDUE_W = 10;
    localparam int MODULUS_W = 10;

    typedef logic [STEP_W-1:0] step_t;

    // Datapath operation selected by the current control word.
    typedef enum logic [2:0] {
        OP_ACCEPT     = 3'd0,
        OP_BUILD_INIT = 3'd1,
        OP_BUILD      = 3'd2,
        OP_MOD_INIT   = 3'd3,
        OP_MOD_STEP   = 3'd4,
        OP_READ       = 3'd5,
        OP_EMIT       = 3'd6
    } op_t;

    // Condition that makes the sequencer take the jump target.
    typedef enum logic [2:0] {
        C_ALWAYS    = 3'd0,
        C_IN        = 3'd1,
        C_VALID     = 3'd2,
        C_BUILD_END = 3'd3,
        C_MOD_END   = 3'd4,
        C_OUT_FREE  = 3'd5
    } cond_t;

    // When the condition fails, hold stays on the step; otherwise fall through.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        logic  hold;
    } ctrl_word_t;

    localparam step_t ST_WAIT  = 3'd0;
    localparam step_t ST_CHECK = 3'd1;
    localparam step_t ST_BUILD = 3'd2;
    localparam step_t ST_MODI  = 3'd3;
    localparam step_t ST_MODL  = 3'd4;
    localparam step_t ST_READ  = 3'd5;
    localparam step_t ST_EMIT  = 3'd6;

    function automatic ctrl_word_t program_word(input step_t step);
        ctrl_word_t w;
        case (step)
            ST_WAIT:  w = '{op: OP_ACCEPT,     cond: C_IN,        target: ST_CHECK, hold: 1'b1};
            ST_CHECK: w = '{op: OP_BUILD_INIT, cond: C_VALID,     target: ST_MODI,  hold: 1'b0};
            ST_BUILD: w = '{op: OP_BUILD,      cond: C_BUILD_END, target: ST_MODI,  hold: 1'b1};
            ST_MODI:  w = '{op: OP_MOD_INIT,   cond: C_ALWAYS,    target: ST_MODL,  hold: 1'b0};
            ST_MODL:  w = '{op: OP_MOD_STEP,   cond: C_MOD_END,   target: ST_READ,  hold: 1'b1};
            ST_READ:  w = '{op: OP_READ,       cond: C_ALWAYS,    target: ST_EMIT,  hold: 1'b0};
            ST_EMIT:  w = '{op: OP_EMIT,       cond: C_OUT_FREE,  target: ST_WAIT,  hold: 1'b1};
            default:  w = '{op: OP_ACCEPT,     cond: C_ALWAYS,    target: ST_WAIT,  hold: 1'b0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fpp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module fpp_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fibonacci_modulo_pisano.sv -----
// Fibonacci residue block: F(n) mod m through a Pisano period table; uses fpp_pkg, fpp_ram.
// After acceptance a lookup passes through the check, remainder init, remainder loop, read
// and emit steps; the loop forms the bit-serial remainder of the index by the period, one
// index bit per cycle. A new request is accepted only once the last result is in the output register.
// A rebuild on the first request after reset or a modulus write runs before the remainder steps.
// Reset (rst_n, asynchronous, active low) sets modulus 2 and marks the table stale.
`default_nettype none

module fibonacci_modulo_pisano
    import fpp_pkg::*;
#(
    parameter int MAX_MODULUS = 1000,
    parameter int TABLE_DEPTH = 8192,
    parameter int INDEX_WIDTH = 50
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration: modulus register, written whenever the enable is high.
    input  wire logic                   modulus_wr_en,
    input  wire logic [MODULUS_W-1:0]   modulus,
    // Request channel.
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [INDEX_WIDTH-1:0] fib_index,
    // Result channel.
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [RESIDUE_W-1:0]   residue
);

    // Table address width and the width that can hold a period equal to the depth.
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int PER_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W  = $clog2(INDEX_WIDTH);

    // Effective clamp value; moduli above what the 10-bit register holds never clamp.
    localparam logic [MODULUS_W-1:0] MOD_CLAMP =
        (MAX_MODULUS > (1 << MODULUS_W) - 1) ? {MODULUS_W{1'b1}} : MODULUS_W'(MAX_MODULUS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_LOAD  = CNT_W'(INDEX_WIDTH - 1);

    // Sequencer state.
    step_t      step_reg, step_next;
    ctrl_word_t cw;
    logic       cond_true;

    // Configuration and table status.
    logic [MODULUS_W-1:0] modulus_reg;
    logic                 table_valid_reg, table_valid_next;
    logic [PER_W-1:0]     period_reg, period_next;

    // Rebuild datapath: the running pair (a, b), the effective modulus and its "one".
    logic [RESIDUE_W-1:0] fa_reg, fa_next;
    logic [RESIDUE_W-1:0] fb_reg, fb_next;
    logic [MODULUS_W-1:0] m_reg, m_next;
    logic [RESIDUE_W-1:0] one_reg, one_next;
    logic [ADDR_W-1:0]    wr_idx_reg, wr_idx_next;
    logic [RESIDUE_W:0]   pair_sum;
    logic [RESIDUE_W-1:0] pair_mod;
    logic                 pair_repeat;
    logic                 build_end;
    logic [MODULUS_W-1:0] m_eff;

    // Remainder datapath: index shifts out MSB first into a restoring remainder.
    logic [INDEX_WIDTH-1:0] idx_reg, idx_next;
    logic [PER_W-1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [PER_W:0]         rem_shift;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [RESIDUE_W-1:0] residue_reg, residue_next;
    logic                 out_free;

    logic [RESIDUE_W-1:0] ram_rd_data;
    logic                 ram_wr_en;
    logic                 ram_rd_en;

    assign cw        = program_word(step_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (cw.op == OP_ACCEPT);
    assign out_valid = out_valid_reg;
    assign residue   = residue_reg;

    // Effective modulus: codes 0 and 1 behave as modulus 1; large codes clamp.
    always_comb
    begin
        if (modulus_reg < MODULUS_W'(2))
        begin
            m_eff = MODULUS_W'(1);
        end
        else if (modulus_reg > MOD_CLAMP)
        begin
            m_eff = MOD_CLAMP;
        end
        else
        begin
            m_eff = modulus_reg;
        end
    end

    // Next Fibonacci residue; both operands are below m so one subtract suffices.
    // The period ends when the new pair (b, s) equals (0, one), or when the table is full.
    assign pair_sum    = {1'b0, fa_reg} + {1'b0, fb_reg};
    assign pair_mod    = (pair_sum >= {1'b0, m_reg}) ? RESIDUE_W'(pair_sum - {1'b0, m_reg})
                                                     : pair_sum[RESIDUE_W-1:0];
    assign pair_repeat = (fb_reg == '0) && (pair_mod == one_reg);
    assign build_end   = pair_repeat || (wr_idx_reg == LAST_ADDR);

    assign rem_shift = {rem_reg, idx_reg[INDEX_WIDTH-1]};

    always_comb
    begin
        case (cw.cond)
            C_ALWAYS:    cond_true = 1'b1;
            C_IN:        cond_true = in_valid;
            C_VALID:     cond_true = table_valid_reg;
            C_BUILD_END: cond_true = build_end;
            C_MOD_END:   cond_true = (cnt_reg == '0);
            C_OUT_FREE:  cond_true = out_free;
            default:     cond_true = 1'b1;
        endcase

        if (cond_true)
        begin
            step_next = cw.target;
        end
        else if (cw.hold)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = step_reg + step_t'(1);
        end
    end

    // Datapath actions of each operation.
    always_comb
    begin
        table_valid_next = table_valid_reg;
        period_next      = period_reg;
        fa_next          = fa_reg;
        fb_next          = fb_reg;
        m_next           = m_reg;
        one_next         = one_reg;
        wr_idx_next      = wr_idx_reg;
        idx_next         = idx_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        residue_next     = residue_reg;
        ram_wr_en        = 1'b0;
        ram_rd_en        = 1'b0;

        case (cw.op)
            OP_ACCEPT:
            begin
                if (in_valid)
                begin
                    idx_next = fib_index;
                end
            end
            OP_BUILD_INIT:
            begin
                m_next      = m_eff;
                one_next    = (m_eff == MODULUS_W'(1)) ? '0 : RESIDUE_W'(1);
                fa_next     = '0;
                fb_next     = (m_eff == MODULUS_W'(1)) ? '0 : RESIDUE_W'(1);
                wr_idx_next = '0;
            end
            OP_BUILD:
            begin
                ram_wr_en   = 1'b1;
                fa_next     = fb_reg;
                fb_next     = pair_mod;
                wr_idx_next = wr_idx_reg + ADDR_W'(1);
                if (build_end)
                begin
                    period_next      = PER_W'({1'b0, wr_idx_reg} + (ADDR_W + 1)'(1));
                    table_valid_next = 1'b1;
                end
            end
            OP_MOD_INIT:
            begin
                rem_next = '0;
                cnt_next = CNT_LOAD;
            end
            OP_MOD_STEP:
            begin
                idx_next = {idx_reg[INDEX_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (rem_shift >= {1'b0, period_reg})
                begin
                    rem_next = PER_W'(rem_shift - {1'b0, period_reg});
                end
                else
                begin
                    rem_next = rem_shift[PER_W-1:0];
                end
            end
            OP_READ:
            begin
                ram_rd_en = 1'b1;
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    residue_next   = ram_rd_data;
                end
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase

        // Modulus write makes the table stale; user writes only while the block is idle, unchecked.
        if (modulus_wr_en)
        begin
            table_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= ST_WAIT;
            modulus_reg     <= MODULUS_W'(2);
            table_valid_reg <= 1'b0;
            period_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            step_reg        <= step_next;
            table_valid_reg <= table_valid_next;
            period_reg      <= period_next;
            out_valid_reg   <= out_valid_next;
            if (modulus_wr_en)
            begin
                modulus_reg <= modulus;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        fa_reg      <= fa_next;
        fb_reg      <= fb_next;
        m_reg       <= m_next;
        one_reg     <= one_next;
        wr_idx_reg  <= wr_idx_next;
        idx_reg     <= idx_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        residue_reg <= residue_next;
    end

    // Residue table: written during a rebuild, read once per request at n mod period.
    // The remainder is below the period, which never exceeds the depth.
    fpp_ram #(
        .WIDTH (RESIDUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data (fa_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (rem_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Testbench for fibonacci_modulo_pisano. It sends Fibonacci index requests through the
// valid/ready channels and checks every residue against a Pisano-table model of its own.
// Depends on fpp_pkg for the residue and modulus widths, and on the block's RTL.

module tb;
    import fpp_pkg::*;

    localparam int MAX_MOD       = 1000;
    localparam int TBL_DEPTH     = 8192;
    localparam int IDX_W         = 50;
    // One lookup is a bit-serial remainder over the index plus a few control steps.
    localparam int LOOKUP_CYCLES = IDX_W + 6;

    typedef logic [IDX_W-1:0]     index_t;
    typedef logic [RESIDUE_W-1:0] residue_t;
    typedef logic [MODULUS_W-1:0] modulus_t;

    // One request on its way through the block, with the residue it must return.
    typedef struct {
        index_t   idx;
        residue_t res;
    } lookup_t;

    logic     clk           = 1'b0;
    logic     rst_n         = 1'b0;
    logic     modulus_wr_en = 1'b0;
    modulus_t modulus       = '0;
    logic     in_valid      = 1'b0;
    logic     in_ready;
    index_t   fib_index     = '0;
    logic     out_valid;
    logic     out_ready     = 1'b0;
    residue_t residue;

    // Model state: the modulus as last written, the residue sequence over one
    // Pisano period, its length, and whether it matches the current modulus.
    modulus_t    mod_shadow = 10'd2;
    residue_t    residue_cycle [TBL_DEPTH];
    int unsigned cycle_len   = 0;
    bit          cycle_known = 1'b0;

    // Residues still owed by the block, oldest first.
    lookup_t     pending_residues [$];
    int unsigned mismatches = 0;

    // When set, neither side inserts idle cycles.
    bit          steady = 1'b0;

    fibonacci_modulo_pisano #(
        .MAX_MODULUS (MAX_MOD),
        .TABLE_DEPTH (TBL_DEPTH),
        .INDEX_WIDTH (IDX_W)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .modulus_wr_en (modulus_wr_en),
        .modulus       (modulus),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .fib_index     (fib_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .residue       (residue)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Moduli below two behave as a modulus of one, where every residue is zero.
    // Anything above the supported maximum is clamped to it.
    function automatic int unsigned effective_mod(input modulus_t v);
        int unsigned m;
        m = v;
        if (m < 2)
            m = 1;
        if (m > MAX_MOD)
            m = MAX_MOD;
        return m;
    endfunction

    // Walk the sequence mod m until the pair (0, 1 mod m) comes back; that index is the
    // Pisano period. If it never comes back within the table, the table length is used.
    function automatic void build_residue_cycle();
        int unsigned m;
        int unsigned one;
        int unsigned a;
        int unsigned b;
        int unsigned s;
        int unsigned i;
        bit          found;
        m         = effective_mod(mod_shadow);
        one       = 1 % m;
        a         = 0;
        b         = one;
        i         = 0;
        found     = 1'b0;
        cycle_len = TBL_DEPTH;
        while (!found && i < TBL_DEPTH)
        begin
            residue_cycle[i] = residue_t'(a);
            s = a + b;
            if (s >= m)
                s -= m;
            a = b;
            b = s;
            if (a == 0 && b == one)
            begin
                cycle_len = i + 1;
                found     = 1'b1;
            end
            i++;
        end
        cycle_known = 1'b1;
    endfunction

    // F(n) mod m for one accepted request. A stale table is rebuilt first, just as
    // the block rebuilds on the first request after reset or a modulus write.
    function automatic residue_t fib_residue_of(input index_t n);
        longint unsigned pos;
        if (!cycle_known)
            build_residue_cycle();
        if (cycle_len == 0 || cycle_len > TBL_DEPTH)
            cycle_len = TBL_DEPTH;
        pos = 64'(n) % 64'(cycle_len);
        return residue_cycle[pos];
    endfunction

    // Indexes spread over the whole 50-bit range, with extra weight on small values,
    // values near the top, and single-bit patterns.
    function automatic index_t random_index();
        index_t      n;
        int unsigned pick;
        n    = index_t'({$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 20)
            n = index_t'($urandom_range(0, 20000));
        else if (pick < 30)
            n = ~index_t'($urandom_range(0, 20000));
        else if (pick < 40)
            n = index_t'(1) << $urandom_range(0, IDX_W - 1);
        return n;
    endfunction

    // Mostly legal moduli, with the degenerate and clamped ranges visited now and then.
    function automatic modulus_t random_modulus();
        modulus_t v;
        case ($urandom_range(9))
            0:       v = modulus_t'($urandom_range(0, 1));
            1:       v = modulus_t'($urandom_range(MAX_MOD, 1023));
            2:       v = modulus_t'($urandom_range(2, 16));
            default: v = modulus_t'($urandom_range(2, MAX_MOD));
        endcase
        return v;
    endfunction

    // Send one request. Must be called at a rising edge and returns at the edge where
    // the request was accepted, so the next call can keep valid high without a glitch.
    // Outside the steady stretch, about a quarter of requests are preceded by a few idle cycles.
    task automatic send_index(input index_t n);
        int unsigned gap;
        lookup_t     entry;
        gap = 0;
        if (!steady && $urandom_range(99) < 25)
            gap = $urandom_range(1, 8);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        fib_index <= n;
        // Values read right after the edge are the ones the block saw at that edge.
        do
            @(posedge clk);
        while (!in_ready);
        entry.idx = n;
        entry.res = fib_residue_of(n);
        pending_residues.push_back(entry);
    endtask

    // Stop sending and wait until every owed residue has been returned. Each request
    // produces exactly one result, so the block is back in its wait state by then.
    task automatic drain_requests();
        in_valid <= 1'b0;
        while (pending_residues.size() != 0)
            @(posedge clk);
    endtask

    // Modulus writes happen only with the block idle. The model drops its table at
    // the same point the block marks its own stale.
    task automatic write_modulus(input modulus_t v);
        drain_requests();
        modulus_wr_en <= 1'b1;
        modulus       <= v;
        @(posedge clk);
        modulus_wr_en <= 1'b0;
        mod_shadow  = v;
        cycle_known = 1'b0;
    endtask

    // Result checker and receiver. The handshake is sampled with the values the block
    // saw at this edge; out_ready is dropped in about a quarter of cycles unless the
    // run is in its steady stretch.
    always @(posedge clk)
    begin : result_check
        lookup_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_residues.size() == 0)
            begin
                $display("%0t: residue %0d returned with no request pending", $time, residue);
                mismatches++;
            end
            else
            begin
                want = pending_residues.pop_front();
                if (residue !== want.res)
                begin
                    $display("%0t: residue for index %0d: expected %0d, got %0d",
                             $time, want.idx, want.res, residue);
                    mismatches++;
                end
            end
        end
        if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 25);
    end

    // The first requests run on the reset modulus of two, whose period is three.
    // The first of them also forces the initial table build.
    task automatic test_reset_modulus();
        send_index(index_t'(0));
        send_index(index_t'(1));
        send_index(index_t'(2));
        send_index(index_t'(3));
        send_index('1);
        send_index(index_t'(1) << (IDX_W - 1));
    endtask

    // Corner moduli: zero and one act as one, 1023 clamps to the maximum, the maximum
    // itself (period 1500, so requests around the period boundary), a rewrite of the
    // same value which must still trigger a rebuild, and a small modulus at its period.
    task automatic test_modulus_corners();
        write_modulus(modulus_t'(0));
        send_index(index_t'(5));
        send_index('1);
        write_modulus(modulus_t'(1));
        send_index(index_t'(7));
        write_modulus(modulus_t'(1023));
        send_index(index_t'(0));
        send_index(index_t'(1));
        send_index(index_t'(1500));
        send_index(index_t'(1501));
        send_index('1);
        write_modulus(modulus_t'(MAX_MOD));
        send_index(index_t'(2999));
        write_modulus(modulus_t'(MAX_MOD));
        send_index(index_t'(12345));
        write_modulus(modulus_t'(10));
        send_index(index_t'(59));
        send_index(index_t'(60));
        send_index(index_t'(61));
    endtask

    // Random phases: each picks a fresh modulus and runs a burst of random requests
    // against it, so the table is rebuilt many times over the run.
    task automatic test_random_lookups(input int unsigned total);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < total)
        begin
            write_modulus(random_modulus());
            burst = $urandom_range(60, 200);
            if (burst > total - sent)
                burst = total - sent;
            repeat (burst)
                send_index(random_index());
            sent += burst;
        end
    endtask

    // A long stretch with requests offered back to back and results always taken,
    // on a modulus with a Pisano period of 1500.
    task automatic test_back_to_back(input int unsigned total);
        write_modulus(modulus_t'(250));
        steady = 1'b1;
        repeat (total)
            send_index(random_index());
        drain_requests();
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_modulus();
        test_modulus_corners();
        test_random_lookups(700);
        test_back_to_back(200);
        test_random_lookups(630);

        // Let any stray result show up before the verdict.
        drain_requests();
        repeat (LOOKUP_CYCLES + 8) @(posedge clk);
        if (mismatches == 0)
            $display("fibonacci_modulo_pisano test passed");
        else
            $display("fibonacci_modulo_pisano test failed");
        $finish;
    end

    // A run that hangs ends here with a failure verdict.
    initial
    begin
        #20000000;
        $display("fibonacci_modulo_pisano test failed");
        $finish;
    end

endmodule
